// ===== sv/nearest_entry_focus_tracker_top_assert.svh =====
// ----------------------------------------------------------------------------
// Nearest entry focus tracker assertion macros
// Clocked implication checks shared by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef NEAREST_ENTRY_FOCUS_TRACKER_TOP_ASSERT_SVH
`define NEAREST_ENTRY_FOCUS_TRACKER_TOP_ASSERT_SVH

// same-cycle implication
`define NEFT_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NEFT_ASSERT_NXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/neft_pkg.sv =====
// ----------------------------------------------------------------------------
// Nearest entry focus tracker package
// Sizes, command and event codes, table entry and event types.
// ----------------------------------------------------------------------------
`default_nettype none

package neft_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int COORD_BITS  = 24;
  localparam int ID_BITS     = 16;

  localparam int IDX_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
  localparam int SQ_BITS   = 2 * COORD_BITS;
  localparam int DIST_BITS = SQ_BITS + 2;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    EV_ADDED   = 3'd0,
    EV_REMOVED = 3'd1,
    EV_LOST    = 3'd2,
    EV_GAINED  = 3'd3,
    EV_FULL    = 3'd4
  } ev_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        [ID_BITS-1:0]    id;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } entry_t;

  typedef struct packed {
    ev_kind_t kind;
    entry_t   ent;
  } event_t;

endpackage

`default_nettype wire

// ===== sv/nearest_entry_focus_tracker_top.sv =====
// Flow: an accepted beat is checked against every stored entry in order through
// the table read register and the scan pipeline, then decided; results follow in turn.
// A remove also moves each entry stored after the removed one down by one slot.
// A new beat is stalled until the last one is fully done, results included, as the
// scan walks the table in order through the single read port of the table memory.
// Reset: synchronous, active low; empties the table and drops the focus.
// ----------------------------------------------------------------------------
// Nearest entry focus tracker
// Ordered id/point table in one synchronous memory; add, remove and a
// pipelined nearest-point scan that reports focus changes as event beats.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_entry_focus_tracker_top_assert.svh"

module nearest_entry_focus_tracker_top
  import neft_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,

  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic        [1:0]            in_cmd,
  input  wire logic        [ID_BITS-1:0]    in_entry_id,
  input  wire logic signed [COORD_BITS-1:0] in_point_x,
  input  wire logic signed [COORD_BITS-1:0] in_point_y,
  input  wire logic signed [COORD_BITS-1:0] in_point_z,

  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic             [2:0]            out_event_kind,
  output logic             [ID_BITS-1:0]    out_event_id,
  output logic signed      [COORD_BITS-1:0] out_event_x,
  output logic signed      [COORD_BITS-1:0] out_event_y,
  output logic signed      [COORD_BITS-1:0] out_event_z,
  output logic                              out_last_event
);

  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    abs_diff = d[COORD_BITS] ? COORD_BITS'(-d) : d[COORD_BITS-1:0];
  endfunction

  // table memory
  entry_t                mem [TABLE_DEPTH];
  entry_t                mem_rdata_r;
  logic                  mem_we;
  logic [IDX_BITS-1:0]   mem_waddr;
  entry_t                mem_wdata;
  logic                  mem_re;
  logic [IDX_BITS-1:0]   mem_raddr;

  // control
  state_t                state_r, state_nxt;
  logic [CNT_BITS-1:0]   fill_r, fill_nxt;
  logic [CNT_BITS-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic [IDX_BITS-1:0]   shift_k_r, shift_k_nxt;
  logic                  focus_valid_r, focus_valid_nxt;
  logic [ID_BITS-1:0]    focus_id_r, focus_id_nxt;
  event_t                ev_a_r, ev_a_nxt;
  event_t                ev_b_r, ev_b_nxt;
  logic [1:0]            ev_n_r, ev_n_nxt;
  logic                  out_valid_r, out_valid_nxt;
  event_t                out_ev_r, out_ev_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [1:0]            cmd_r;
  entry_t                key_r;

  // scan pipeline
  logic                  scan_issue;
  logic                  in_accept;
  logic                  p1_vld_r, p2_vld_r, p3_vld_r;
  logic [IDX_BITS-1:0]   p1_idx_r;
  logic [ID_BITS-1:0]    p2_id_r, p3_id_r;
  logic [COORD_BITS-1:0] dx_r, dy_r, dz_r;
  logic [SQ_BITS-1:0]    sqx_r, sqy_r, sqz_r;
  logic [DIST_BITS-1:0]  dist_sum;
  logic                  have_r;
  logic [DIST_BITS-1:0]  best_dist_r;
  logic [ID_BITS-1:0]    best_id_r;
  logic                  found_r;
  logic [IDX_BITS-1:0]   found_idx_r;
  entry_t                found_ent_r;
  logic [CNT_BITS-1:0]   shift_next;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign scan_issue = (state_r == ST_SCAN) && (scan_cnt_r < fill_r);
  assign shift_next = CNT_BITS'(shift_k_r) + CNT_BITS'(1);
  assign dist_sum   = DIST_BITS'(sqx_r) + DIST_BITS'(sqy_r) + DIST_BITS'(sqz_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // latch the beat, run the scan pipeline
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r <= in_cmd;
      key_r <= '{id: in_entry_id, x: in_point_x, y: in_point_y, z: in_point_z};
    end
    p1_idx_r <= scan_cnt_r[IDX_BITS-1:0];
    p2_id_r  <= mem_rdata_r.id;
    dx_r     <= abs_diff(key_r.x, mem_rdata_r.x);
    dy_r     <= abs_diff(key_r.y, mem_rdata_r.y);
    dz_r     <= abs_diff(key_r.z, mem_rdata_r.z);
    p3_id_r  <= p2_id_r;
    sqx_r    <= dx_r * dx_r;
    sqy_r    <= dy_r * dy_r;
    sqz_r    <= dz_r * dz_r;
    if (p1_vld_r && !found_r && (mem_rdata_r.id == key_r.id)) begin
      found_idx_r <= p1_idx_r;
      found_ent_r <= mem_rdata_r;
    end
    if (p3_vld_r && (!have_r || (dist_sum < best_dist_r))) begin
      best_dist_r <= dist_sum;
      best_id_r   <= p3_id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      found_r  <= 1'b0;
      have_r   <= 1'b0;
    end else begin
      p1_vld_r <= scan_issue;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      if (in_accept) begin
        found_r <= 1'b0;
        have_r  <= 1'b0;
      end else begin
        if (p1_vld_r && (mem_rdata_r.id == key_r.id)) begin
          found_r <= 1'b1;
        end
        if (p3_vld_r) begin
          have_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      fill_r        <= '0;
      scan_cnt_r    <= '0;
      shift_k_r     <= '0;
      focus_valid_r <= 1'b0;
      focus_id_r    <= '0;
      ev_n_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      fill_r        <= fill_nxt;
      scan_cnt_r    <= scan_cnt_nxt;
      shift_k_r     <= shift_k_nxt;
      focus_valid_r <= focus_valid_nxt;
      focus_id_r    <= focus_id_nxt;
      ev_n_r        <= ev_n_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_a_r     <= ev_a_nxt;
    ev_b_r     <= ev_b_nxt;
    out_ev_r   <= out_ev_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    fill_nxt        = fill_r;
    scan_cnt_nxt    = scan_cnt_r;
    shift_k_nxt     = shift_k_r;
    focus_valid_nxt = focus_valid_r;
    focus_id_nxt    = focus_id_r;
    ev_a_nxt        = ev_a_r;
    ev_b_nxt        = ev_b_r;
    ev_n_nxt        = ev_n_r;
    out_ev_nxt      = out_ev_r;
    out_last_nxt    = out_last_r;
    out_valid_nxt   = out_valid_r && out_stall;
    mem_we          = 1'b0;
    mem_waddr       = scan_cnt_r[IDX_BITS-1:0];
    mem_wdata       = key_r;
    mem_re          = scan_issue;
    mem_raddr       = scan_cnt_r[IDX_BITS-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          scan_cnt_nxt = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_issue) begin
          scan_cnt_nxt = scan_cnt_r + CNT_BITS'(1);
        end else if (!p1_vld_r && !p2_vld_r && !p3_vld_r) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = ST_IDLE;
        unique case (cmd_r)
          CMD_ADD: begin
            if (!found_r) begin
              ev_n_nxt  = 2'd1;
              state_nxt = ST_EMIT;
              if (fill_r == CNT_BITS'(TABLE_DEPTH)) begin
                ev_a_nxt        = '0;
                ev_a_nxt.kind   = EV_FULL;
                ev_a_nxt.ent.id = key_r.id;
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = fill_r[IDX_BITS-1:0];
                fill_nxt      = fill_r + CNT_BITS'(1);
                ev_a_nxt.kind = EV_ADDED;
                ev_a_nxt.ent  = key_r;
              end
            end
          end
          CMD_REMOVE: begin
            if (found_r) begin
              ev_a_nxt.kind = EV_REMOVED;
              ev_a_nxt.ent  = found_ent_r;
              ev_n_nxt      = 2'd1;
              shift_k_nxt   = found_idx_r;
              state_nxt     = ST_SHIFT_RD;
            end
          end
          CMD_TICK: begin
            if (!(have_r && focus_valid_r && (focus_id_r == best_id_r))) begin
              focus_valid_nxt = have_r;
              focus_id_nxt    = have_r ? best_id_r : '0;
              if (focus_valid_r) begin
                ev_a_nxt        = '0;
                ev_a_nxt.kind   = EV_LOST;
                ev_a_nxt.ent.id = focus_id_r;
                ev_b_nxt        = '0;
                ev_b_nxt.kind   = EV_GAINED;
                ev_b_nxt.ent.id = best_id_r;
                ev_n_nxt        = have_r ? 2'd2 : 2'd1;
                state_nxt       = ST_EMIT;
              end else if (have_r) begin
                ev_a_nxt        = '0;
                ev_a_nxt.kind   = EV_GAINED;
                ev_a_nxt.ent.id = best_id_r;
                ev_n_nxt        = 2'd1;
                state_nxt       = ST_EMIT;
              end
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_SHIFT_RD: begin
        if (shift_next < fill_r) begin
          mem_re    = 1'b1;
          mem_raddr = shift_next[IDX_BITS-1:0];
          state_nxt = ST_SHIFT_WR;
        end else begin
          fill_nxt  = fill_r - CNT_BITS'(1);
          state_nxt = ST_EMIT;
        end
      end
      ST_SHIFT_WR: begin
        mem_we      = 1'b1;
        mem_waddr   = shift_k_r;
        mem_wdata   = mem_rdata_r;
        shift_k_nxt = shift_next[IDX_BITS-1:0];
        state_nxt   = ST_SHIFT_RD;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = ev_a_r;
          out_last_nxt  = (ev_n_r == 2'd1);
          if (ev_n_r == 2'd2) begin
            ev_a_nxt = ev_b_r;
            ev_n_nxt = 2'd1;
          end else begin
            ev_n_nxt  = 2'd0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_ev_r.kind;
  assign out_event_id   = out_ev_r.ent.id;
  assign out_event_x    = out_ev_r.ent.x;
  assign out_event_y    = out_ev_r.ent.y;
  assign out_event_z    = out_ev_r.ent.z;
  assign out_last_event = out_last_r;

  `NEFT_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CNT_BITS'(TABLE_DEPTH), "fill overflow")
  `NEFT_ASSERT_NXT(a_accept_busy, clk, rst_n, in_accept, state_r == ST_SCAN, "beat not scanned")
  `NEFT_ASSERT_IMP(a_emit_pending, clk, rst_n, state_r == ST_EMIT, ev_n_r != 2'd0, "emit w/o event")
  `NEFT_ASSERT_NXT(a_focus_hold, clk, rst_n, state_r != ST_DECIDE, $stable(focus_valid_r), "focus moved")

endmodule

`default_nettype wire
